@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define LPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lpc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int COORD_W    = 32;
  localparam int COEF_W     = 32;
  localparam int SUM_W      = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int DIM_REG_W  = 11;
  localparam int N_COEF_REG = 6;
  localparam int PIX_ADDR_W = 10;
  localparam int TRANS_SHIFT = 14;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_R0_C01  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_R0_C23  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_R1_C01  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_R1_C23  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_R2_C01  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_R2_C23  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd7;

  localparam logic [DIM_REG_W-1:0] DIM_RESET = 11'd1024;

  // Input item modes
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_POINT = 1'b1;

  typedef struct packed {
    logic                       mode;
    logic [PIX_ADDR_W-1:0]      pix_row;
    logic [PIX_ADDR_W-1:0]      pix_col;
    logic [7:0]                 pix_blue;
    logic [7:0]                 pix_green;
    logic [7:0]                 pix_red;
    logic signed [COORD_W-1:0]  pt_x;
    logic signed [COORD_W-1:0]  pt_y;
    logic signed [COORD_W-1:0]  pt_z;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic signed [COORD_W-1:0]  out_z;
    logic [7:0]                 out_red;
    logic [7:0]                 out_green;
    logic [7:0]                 out_blue;
  } out_word_t;

endpackage

`default_nettype wire

@@ hdl/lpc_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface lpc_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/lidar_point_colorizer.sv @@
// A point word passes the product, row-sum and divisor stages, the range pre-check, the
// quotient stages, the address stage and the store read to the output register.
// Throughput: one word per cycle while out_ch.ready is high or the output register is empty;
// the one-bit-per-stage quotient pipeline and the single store port each take a word a cycle.
// Reset: synchronous, active high; clears valid bits, coefficients to 0, size to 1024.
// The pixel store has no reset and holds garbage until written.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lidar_point_colorizer #(
  parameter int MAX_WIDTH  = lpc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lpc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]   cfg_data,
  lpc_stream_if.sink                       in_ch,
  lpc_stream_if.source                     out_ch
);

  localparam int QW    = ($clog2(MAX_WIDTH) > $clog2(MAX_HEIGHT)) ?
                         $clog2(MAX_WIDTH) : $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = lpc_pkg::SUM_W;
  localparam int RW    = SW + QW;
  localparam int CMPW  = (QW > lpc_pkg::DIM_REG_W) ? QW : lpc_pkg::DIM_REG_W;

  // Config registers
  logic [lpc_pkg::CFG_DATA_W-1:0] coef [lpc_pkg::N_COEF_REG];
  logic [lpc_pkg::DIM_REG_W-1:0]  image_width;
  logic [lpc_pkg::DIM_REG_W-1:0]  image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lpc_pkg::N_COEF_REG; i++) coef[i] <= '0;
      image_width  <= lpc_pkg::DIM_RESET;
      image_height <= lpc_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lpc_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[lpc_pkg::DIM_REG_W-1:0];
        lpc_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[lpc_pkg::DIM_REG_W-1:0];
        default: begin
          if (int'(cfg_index) < lpc_pkg::N_COEF_REG) coef[cfg_index] <= cfg_data;
        end
      endcase
    end
  end

  // Coefficient halves, signed Q18.14
  logic signed [lpc_pkg::COEF_W-1:0] c [3][4];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 4; k++) begin
        c[r][k] = signed'(coef[2*r + k/2][lpc_pkg::COEF_W*(k%2) +: lpc_pkg::COEF_W]);
      end
    end
  end

  // Global advance: output slot free or being taken
  logic      adv;
  logic      ovalid;
  lpc_pkg::out_word_t odata;

  assign adv          = !ovalid || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = ovalid;
  assign out_ch.data  = odata;

  // Stage 1: products
  logic                      s1_valid;
  lpc_pkg::in_word_t         s1_item;
  logic signed [SW-1:0]      prod [3][3];

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv) s1_valid <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item <= in_ch.data;
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= c[r][0] * in_ch.data.pt_x;
        prod[r][1] <= c[r][1] * in_ch.data.pt_y;
        prod[r][2] <= c[r][2] * in_ch.data.pt_z;
      end
    end
  end

  // Stage 2: row sums in Q.28
  logic                  s2_valid;
  lpc_pkg::in_word_t     s2_item;
  logic signed [SW-1:0]  sum [3];

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (adv) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_item <= s1_item;
      for (int r = 0; r < 3; r++) begin
        sum[r] <= (prod[r][0] >>> 2) + (prod[r][1] >>> 2) + (prod[r][2] >>> 2)
                + (SW'(c[r][3]) <<< lpc_pkg::TRANS_SHIFT);
      end
    end
  end

  // Stage 3: make the divisor positive, early drops
  logic              s3_valid;
  logic              s3_keep;
  lpc_pkg::in_word_t s3_item;
  logic [SW-1:0]     s3_nu, s3_nv, s3_d;
  logic [SW-1:0]     nu, nv, dd;

  always_comb begin
    nu = sum[2][SW-1] ? SW'(-sum[0]) : SW'(sum[0]);
    nv = sum[2][SW-1] ? SW'(-sum[1]) : SW'(sum[1]);
    dd = sum[2][SW-1] ? SW'(-sum[2]) : SW'(sum[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (adv) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_item <= s2_item;
      s3_nu   <= nu;
      s3_nv   <= nv;
      s3_d    <= dd;
      s3_keep <= (s2_item.mode == lpc_pkg::MODE_POINT) && !s2_item.pt_x[lpc_pkg::COORD_W-1]
              && (sum[2] != '0) && !nu[SW-1] && !nv[SW-1];
    end
  end

  // Quotient pipeline: entry 0 is the range pre-check, then one bit per stage
  logic              dv_valid [QW+1];
  logic              dv_keep  [QW+1];
  lpc_pkg::in_word_t dv_item  [QW+1];
  logic [SW-1:0]     dv_ru    [QW+1];
  logic [SW-1:0]     dv_rv    [QW+1];
  logic [SW-1:0]     dv_d     [QW+1];
  logic [QW-1:0]     dv_qu    [QW+1];
  logic [QW-1:0]     dv_qv    [QW+1];

  always_ff @(posedge clk) begin
    if (rst) dv_valid[0] <= 1'b0;
    else if (adv) dv_valid[0] <= s3_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_item[0] <= s3_item;
      dv_ru[0]   <= s3_nu;
      dv_rv[0]   <= s3_nv;
      dv_d[0]    <= s3_d;
      dv_qu[0]   <= '0;
      dv_qv[0]   <= '0;
      dv_keep[0] <= s3_keep && (RW'(s3_nu) < (RW'(s3_d) << QW))
                            && (RW'(s3_nv) < (RW'(s3_d) << QW));
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [RW-1:0] sh;
    logic          ge_u, ge_v;

    // Restoring step for quotient bit QW-j
    always_comb begin
      sh   = RW'(dv_d[j-1]) << (QW - j);
      ge_u = RW'(dv_ru[j-1]) >= sh;
      ge_v = RW'(dv_rv[j-1]) >= sh;
    end

    always_ff @(posedge clk) begin
      if (rst) dv_valid[j] <= 1'b0;
      else if (adv) dv_valid[j] <= dv_valid[j-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_item[j] <= dv_item[j-1];
        dv_keep[j] <= dv_keep[j-1];
        dv_d[j]    <= dv_d[j-1];
        dv_ru[j]   <= ge_u ? SW'(RW'(dv_ru[j-1]) - sh) : dv_ru[j-1];
        dv_rv[j]   <= ge_v ? SW'(RW'(dv_rv[j-1]) - sh) : dv_rv[j-1];
        dv_qu[j]   <= {dv_qu[j-1][QW-2:0], ge_u};
        dv_qv[j]   <= {dv_qv[j-1][QW-2:0], ge_v};
      end
    end
  end

  // Stage MA: bounds check and store address
  logic              ma_valid, ma_rd, ma_wr;
  logic [AW-1:0]     ma_addr;
  lpc_pkg::in_word_t ma_item;
  logic              pt_in_range, pix_in_range;
  logic [QW-1:0]     col_q, row_q;
  logic [AW-1:0]     pt_addr, pix_addr;

  always_comb begin
    col_q = dv_qu[QW];
    row_q = dv_qv[QW];
    pt_in_range = dv_keep[QW]
      && (CMPW'(col_q) < CMPW'(image_width)) && (32'(col_q) < 32'(MAX_WIDTH))
      && (CMPW'(row_q) < CMPW'(image_height)) && (32'(row_q) < 32'(MAX_HEIGHT));
    pix_in_range = (dv_item[QW].mode == lpc_pkg::MODE_PIXEL)
      && (32'(dv_item[QW].pix_row) < 32'(MAX_HEIGHT))
      && (32'(dv_item[QW].pix_col) < 32'(MAX_WIDTH));
    pt_addr  = AW'(AW'(row_q) * AW'(MAX_WIDTH)) + AW'(col_q);
    pix_addr = AW'(AW'(dv_item[QW].pix_row) * AW'(MAX_WIDTH)) + AW'(dv_item[QW].pix_col);
  end

  always_ff @(posedge clk) begin
    if (rst) ma_valid <= 1'b0;
    else if (adv) ma_valid <= dv_valid[QW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ma_item <= dv_item[QW];
      ma_rd   <= pt_in_range;
      ma_wr   <= pix_in_range;
      ma_addr <= pix_in_range ? pix_addr : pt_addr;
    end
  end

  // Pixel store: one port, writes and reads kept in word order
  logic [23:0] pix_mem [DEPTH];
  logic [23:0] rdata;

  always_ff @(posedge clk) begin
    if (adv && ma_valid) begin
      if (ma_wr) pix_mem[ma_addr] <= {ma_item.pix_red, ma_item.pix_green, ma_item.pix_blue};
      if (ma_rd) rdata <= pix_mem[ma_addr];
    end
  end

  // Stage M: read data returns
  logic              m_valid;
  lpc_pkg::in_word_t m_item;

  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else if (adv) m_valid <= ma_valid && ma_rd;
  end

  always_ff @(posedge clk) begin
    if (adv) m_item <= ma_item;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (adv) ovalid <= m_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      odata.out_x     <= m_item.pt_x;
      odata.out_y     <= m_item.pt_y;
      odata.out_z     <= m_item.pt_z;
      odata.out_red   <= rdata[23:16];
      odata.out_green <= rdata[15:8];
      odata.out_blue  <= rdata[7:0];
    end
  end

  // Checks
  `LPC_ASSERT_NOW(a_rem_lt_div, clk, rst, dv_valid[QW] && dv_keep[QW],
    dv_ru[QW] < dv_d[QW] && dv_rv[QW] < dv_d[QW], "quotient remainder not below divisor")
  `LPC_ASSERT_NOW(a_rd_wr_excl, clk, rst, ma_valid, !(ma_rd && ma_wr),
    "store read and write for one word")
  `LPC_ASSERT_NEXT(a_out_from_read, clk, rst, adv && !m_valid, !ovalid,
    "result word without a store read")

endmodule

`default_nettype wire
